// ===== design/avfe_pkg.sv =====
`default_nettype none

package avfe_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned CntWidth   = $clog2(ValueWidth);
  localparam int unsigned DigWidth   = $clog2(NumDigits + 1);

  localparam logic [7:0] ChOpen  = 8'h3C;  // '<'
  localparam logic [7:0] ChClose = 8'h3E;  // '>'
  localparam logic [7:0] ChColon = 8'h3A;  // ':'
  localparam logic [7:0] ChMinus = 8'h2D;  // '-'
  localparam logic [7:0] ChV     = 8'h56;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChL     = 8'h4C;
  localparam logic [3:0] ChDigitHi = 4'h3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_OPEN,
    S_V,
    S_A,
    S_L,
    S_PCOL,
    S_SIGN,
    S_DIG,
    S_SEP,
    S_HI,
    S_LO,
    S_CLOSE
  } state_e;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = {4'h3, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/ascii_value_frame_encoder_core.sv =====
// A value goes through bit-serial binary-to-BCD conversion, then its leading zero
// digits are dropped, then the frame (10 to 20 bytes) goes out one byte per cycle
// while the output is not stalled. The serial conversion shift register and the
// one-byte output register set the frame rate.
// A new value is taken only between frames; the last byte may still be waiting.
// Reset (rst_ni low, asynchronous) returns to idle with no output word pending.
`default_nettype none

module ascii_value_frame_encoder_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [avfe_pkg::ValueWidth-1:0] value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [7:0]                               out_byte_o,
  output logic                                     last_o
);

  avfe_pkg::state_e state_q, state_d;

  logic [avfe_pkg::ValueWidth-1:0] mag_q, mag_d;
  logic [avfe_pkg::BcdWidth-1:0]   bcd_q, bcd_d, bcd_adj;
  logic [avfe_pkg::CntWidth-1:0]   cnt_q, cnt_d;
  logic [avfe_pkg::DigWidth-1:0]   ndig_q, ndig_d;
  logic                            neg_q, neg_d;
  logic [7:0]                      sum_q, sum_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  logic       in_acc;
  logic       emit_ok;
  logic       emit;
  logic       emit_pay;
  logic [7:0] emit_byte;
  logic       emit_last;

  assign in_stall_o  = (state_q != avfe_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign emit_ok     = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

  // add-3 correction on every BCD digit before the shift
  always_comb begin
    for (int d = 0; d < avfe_pkg::NumDigits; d++) begin
      if (bcd_q[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_q[4*d +: 4];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    cnt_d       = cnt_q;
    ndig_d      = ndig_q;
    neg_d       = neg_q;
    sum_d       = sum_q;
    emit        = 1'b0;
    emit_pay    = 1'b0;
    emit_byte   = avfe_pkg::ChOpen;
    emit_last   = 1'b0;

    case (state_q)
      avfe_pkg::S_IDLE: begin
        if (in_acc) begin
          neg_d  = value_i[avfe_pkg::ValueWidth-1];
          mag_d  = value_i[avfe_pkg::ValueWidth-1] ? (~value_i + 1'b1) : value_i;
          bcd_d  = '0;
          cnt_d  = avfe_pkg::CntWidth'(avfe_pkg::ValueWidth - 1);
          ndig_d = avfe_pkg::DigWidth'(avfe_pkg::NumDigits);
          sum_d  = '0;
          state_d = avfe_pkg::S_CONV;
        end
      end
      avfe_pkg::S_CONV: begin
        bcd_d = {bcd_adj[avfe_pkg::BcdWidth-2:0], mag_q[avfe_pkg::ValueWidth-1]};
        mag_d = {mag_q[avfe_pkg::ValueWidth-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = avfe_pkg::S_SKIP;
        end
      end
      avfe_pkg::S_SKIP: begin
        if (ndig_q > avfe_pkg::DigWidth'(1) &&
            bcd_q[avfe_pkg::BcdWidth-1 -: 4] == 4'd0) begin
          bcd_d  = {bcd_q[avfe_pkg::BcdWidth-5:0], 4'd0};
          ndig_d = ndig_q - 1'b1;
        end else begin
          state_d = avfe_pkg::S_OPEN;
        end
      end
      avfe_pkg::S_OPEN: begin
        emit      = 1'b1;
        emit_byte = avfe_pkg::ChOpen;
        if (emit_ok) state_d = avfe_pkg::S_V;
      end
      avfe_pkg::S_V: begin
        emit      = 1'b1;
        emit_pay  = 1'b1;
        emit_byte = avfe_pkg::ChV;
        if (emit_ok) state_d = avfe_pkg::S_A;
      end
      avfe_pkg::S_A: begin
        emit      = 1'b1;
        emit_pay  = 1'b1;
        emit_byte = avfe_pkg::ChA;
        if (emit_ok) state_d = avfe_pkg::S_L;
      end
      avfe_pkg::S_L: begin
        emit      = 1'b1;
        emit_pay  = 1'b1;
        emit_byte = avfe_pkg::ChL;
        if (emit_ok) state_d = avfe_pkg::S_PCOL;
      end
      avfe_pkg::S_PCOL: begin
        emit      = 1'b1;
        emit_pay  = 1'b1;
        emit_byte = avfe_pkg::ChColon;
        if (emit_ok) state_d = neg_q ? avfe_pkg::S_SIGN : avfe_pkg::S_DIG;
      end
      avfe_pkg::S_SIGN: begin
        emit      = 1'b1;
        emit_pay  = 1'b1;
        emit_byte = avfe_pkg::ChMinus;
        if (emit_ok) state_d = avfe_pkg::S_DIG;
      end
      avfe_pkg::S_DIG: begin
        emit      = 1'b1;
        emit_pay  = 1'b1;
        emit_byte = {avfe_pkg::ChDigitHi, bcd_q[avfe_pkg::BcdWidth-1 -: 4]};
        if (emit_ok) begin
          bcd_d  = {bcd_q[avfe_pkg::BcdWidth-5:0], 4'd0};
          ndig_d = ndig_q - 1'b1;
          if (ndig_q == avfe_pkg::DigWidth'(1)) state_d = avfe_pkg::S_SEP;
        end
      end
      avfe_pkg::S_SEP: begin
        emit      = 1'b1;
        emit_byte = avfe_pkg::ChColon;
        if (emit_ok) state_d = (sum_q[7:4] != 4'd0) ? avfe_pkg::S_HI : avfe_pkg::S_LO;
      end
      avfe_pkg::S_HI: begin
        emit      = 1'b1;
        emit_byte = avfe_pkg::hex_char(sum_q[7:4]);
        if (emit_ok) state_d = avfe_pkg::S_LO;
      end
      avfe_pkg::S_LO: begin
        emit      = 1'b1;
        emit_byte = avfe_pkg::hex_char(sum_q[3:0]);
        if (emit_ok) state_d = avfe_pkg::S_CLOSE;
      end
      avfe_pkg::S_CLOSE: begin
        emit      = 1'b1;
        emit_byte = avfe_pkg::ChClose;
        emit_last = 1'b1;
        if (emit_ok) state_d = avfe_pkg::S_IDLE;
      end
      default: begin
        state_d = avfe_pkg::S_IDLE;
      end
    endcase

    if (emit && emit_ok && emit_pay) begin
      sum_d = sum_q ^ emit_byte;
    end
  end

  // output word register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (emit && emit_ok) begin
      out_valid_d = 1'b1;
      out_byte_d  = emit_byte;
      out_last_d  = emit_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= avfe_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    cnt_q      <= cnt_d;
    ndig_q     <= ndig_d;
    neg_q      <= neg_d;
    sum_q      <= sum_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  a_last_is_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> out_byte_o == avfe_pkg::ChClose)
    else $error("last word is not the closing byte");

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == avfe_pkg::S_CONV)
    else $error("accepted value did not start conversion");

  a_conv_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == avfe_pkg::S_CONV && cnt_q == '0 |=> state_q == avfe_pkg::S_SKIP)
    else $error("conversion did not end after last bit");

  a_digit_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == avfe_pkg::S_DIG |-> ndig_q != '0)
    else $error("digit emitted with no digits left");

  a_close_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == avfe_pkg::S_CLOSE && emit_ok |=> state_q == avfe_pkg::S_IDLE && last_o)
    else $error("frame did not close");

endmodule

`default_nettype wire

// ===== tb/sv/avfe_frame_checker.sv =====
`timescale 1ns / 1ps

module avfe_frame_checker (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  input  wire logic                                   in_stall_i,
  input  wire logic signed [avfe_pkg::ValueWidth-1:0] value_i,
  input  wire logic                                   out_valid_i,
  input  wire logic                                   out_stall_i,
  input  wire logic [7:0]                             out_byte_i,
  input  wire logic                                   last_i,
  output int                                          err_cnt_o,
  output int                                          pending_o
);

  logic [7:0] frame_byte_q[$];
  logic       frame_last_q[$];

  initial begin
    err_cnt_o = 0;
    pending_o = 0;
  end

  function automatic logic [7:0] nibble_to_hex(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end
    return 8'h41 + {4'h0, nib} - 8'd10;
  endfunction

  task automatic queue_word(input logic [7:0] b, input logic l);
    frame_byte_q.push_back(b);
    frame_last_q.push_back(l);
  endtask

  // expected frame for one value: <VAL:[-]digits:checksum>
  task automatic add_frame(input logic [avfe_pkg::ValueWidth-1:0] raw);
    logic             neg;
    logic [31:0]      mag;
    logic [7:0]       dig[10];
    int               nd;
    logic [7:0]       pay[$];
    logic [7:0]       sum;
    neg = raw[avfe_pkg::ValueWidth-1];
    mag = neg ? (32'd0 - raw) : raw;
    nd  = 0;
    do begin
      dig[nd] = 8'h30 + 8'(mag % 32'd10);
      mag     = mag / 32'd10;
      nd++;
    end while (mag != 0);
    pay = '{avfe_pkg::ChV, avfe_pkg::ChA, avfe_pkg::ChL, avfe_pkg::ChColon};
    if (neg) begin
      pay.push_back(avfe_pkg::ChMinus);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      pay.push_back(dig[i]);
    end
    sum = 8'h00;
    foreach (pay[i]) begin
      sum ^= pay[i];
    end
    queue_word(avfe_pkg::ChOpen, 1'b0);
    foreach (pay[i]) begin
      queue_word(pay[i], 1'b0);
    end
    queue_word(avfe_pkg::ChColon, 1'b0);
    if (sum >= 8'd16) begin
      queue_word(nibble_to_hex(sum[7:4]), 1'b0);
    end
    queue_word(nibble_to_hex(sum[3:0]), 1'b0);
    queue_word(avfe_pkg::ChClose, 1'b1);
  endtask

  always @(posedge clk_i) begin
    logic [7:0] eb;
    logic       el;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (frame_byte_q.size() == 0) begin
          err_cnt_o++;
          if (err_cnt_o <= 10) begin
            $display("unexpected word: byte %h last %b", out_byte_i, last_i);
          end
        end else begin
          eb = frame_byte_q.pop_front();
          el = frame_last_q.pop_front();
          if (out_byte_i !== eb || last_i !== el) begin
            err_cnt_o++;
            if (err_cnt_o <= 10) begin
              $display("mismatch: byte exp %h got %h, last exp %b got %b",
                       eb, out_byte_i, el, last_i);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        add_frame(value_i);
      end
    end
    pending_o = frame_byte_q.size();
  end

endmodule

// ===== tb/sv/ascii_value_frame_encoder_core_tb.sv =====
`timescale 1ns / 1ps

module ascii_value_frame_encoder_core_tb;

  localparam int CycleLimit = 1000000;
  localparam int NumRandom  = 138;

  logic                                   clk_i       = 1'b0;
  logic                                   rst_ni      = 1'b0;
  logic                                   in_valid_i  = 1'b0;
  logic signed [avfe_pkg::ValueWidth-1:0] value_i     = '0;
  logic                                   out_stall_i = 1'b0;
  logic                                   in_stall_o;
  logic                                   out_valid_o;
  logic [7:0]                             out_byte_o;
  logic                                   last_o;
  int                                     err_cnt;
  int                                     pending;
  int                                     cycles = 0;
  bit                                     no_idle = 1'b0;

  int stall_mode = 0;
  int mode_left  = 0;
  int stall_left = 0;

  ascii_value_frame_encoder_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o)
  );

  avfe_frame_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .value_i    (value_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_i (out_byte_o),
    .last_i     (last_o),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("ascii_value_frame_encoder_core_tb: done, errors");
      $finish;
    end
  end

  // receiver back-pressure: phases of none, light and heavy stalling
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (stall_mode != 0 &&
                 $urandom_range(0, 9) < ((stall_mode == 1) ? 2 : 5)) begin
      out_stall_i <= 1'b1;
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_idle) begin
      return 0;
    end
    if (r < 12) begin
      return $urandom_range(0, 2);
    end
    if (r < 19) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic logic signed [avfe_pkg::ValueWidth-1:0] pick_value();
    int                                     kind;
    int                                     nd;
    int unsigned                            span;
    logic signed [avfe_pkg::ValueWidth-1:0] v;
    kind = $urandom_range(0, 3);
    case (kind)
      0: begin
        v = $urandom;
      end
      1: begin
        v = $urandom_range(0, 99);
      end
      2: begin
        nd   = $urandom_range(1, 9);
        span = 1;
        repeat (nd) span = span * 10;
        v = $urandom_range(span / 10, span - 1);
      end
      default: begin
        v = 32'h7FFF_FFFF - $urandom_range(0, 1000);
      end
    endcase
    if ($urandom_range(0, 1) != 0) begin
      v = -v;
    end
    return v;
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_value(input logic signed [avfe_pkg::ValueWidth-1:0] v,
                            input int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  logic signed [avfe_pkg::ValueWidth-1:0] directed[$];

  initial begin
    directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
                 32'sd99, 32'sd100, 32'sd12345, -32'sd54321, 32'sd999999999,
                 32'sd1000000000, -32'sd1000000000, 32'sd2147483647,
                 -32'sd2147483647, 32'sh8000_0000, 32'sh5555_5555,
                 32'shAAAA_AAAA, 32'sd7, -32'sd16, 32'sd42};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) begin
      send_value(directed[i], pick_gap());
    end
    for (int n = 0; n < NumRandom; n++) begin
      no_idle = (n >= 80 && n < 110);
      if (n == 40 || n == 120) begin
        in_valid_i <= 1'b0;
        wait (pending == 0);
        @(negedge clk_i);
      end
      send_value(pick_value(), pick_gap());
    end
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (80) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("ascii_value_frame_encoder_core_tb: done, clean");
    end else begin
      $display("ascii_value_frame_encoder_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/avfe_pkg.sv
design/ascii_value_frame_encoder_core.sv
tb/sv/avfe_frame_checker.sv
tb/sv/ascii_value_frame_encoder_core_tb.sv
